FILE: rtl/core/pfn_pkg.sv
// ----------------------------------------------------------------------------
// pfn_pkg: shared definitions for the polygon face normal unit
// Field types, word widths and fixed-point constants used by the channel
// interfaces and the datapath.
// ----------------------------------------------------------------------------
package pfn_pkg;

  // Largest number of vertices taken into one polygon; later ones are dropped.
  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W  = 16;
  localparam int NORMAL_W = 16;

  // Coordinate sum or difference of one edge.
  localparam int EDGE_W = COORD_W + 1;
  // Running Newell sums: one edge term needs 34 bits, plus growth per edge.
  localparam int SUM_W  = 36 + $clog2(MAX_VERTICES);
  localparam int MAG_W  = SUM_W;

  // The largest normalized magnitude sits in [2^29, 2^30).
  localparam int SCALED_W = 30;
  localparam int MUL_W    = SCALED_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_W     = 2 * SCALED_W + 2;
  localparam int ROOT_W   = SQ_W + 1;
  localparam int LEN_W    = SCALED_W + 1;
  localparam int SUB_W    = ROOT_W + 1;

  // Q1.14 output: quotient bits and numerator layout of the final division.
  localparam int FRAC_W  = 15;
  localparam int NUM_W   = SCALED_W + FRAC_W + 1;
  localparam int DIV_W   = LEN_W + 1;
  localparam int BITCNT_W = $clog2(FRAC_W);

  localparam logic signed [NORMAL_W-1:0] UNIT_ONE = 16'sd16384;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORMAL_W-1:0] normal_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

endpackage

FILE: rtl/core/pfn_vertex_if.sv
// ----------------------------------------------------------------------------
// pfn_vertex_if: vertex input channel
// Valid/ready channel that carries one polygon vertex per transfer.
// ----------------------------------------------------------------------------
interface pfn_vertex_if;

  logic            valid;
  logic            ready;
  pfn_pkg::coord_t coord_x;
  pfn_pkg::coord_t coord_y;
  pfn_pkg::coord_t coord_z;
  logic            last_vertex;

  modport source (
    output valid,
    output coord_x,
    output coord_y,
    output coord_z,
    output last_vertex,
    input  ready
  );

  modport sink (
    input  valid,
    input  coord_x,
    input  coord_y,
    input  coord_z,
    input  last_vertex,
    output ready
  );

endinterface

FILE: rtl/core/pfn_normal_if.sv
// ----------------------------------------------------------------------------
// pfn_normal_if: normal output channel
// Valid/ready channel that carries one unit face normal per transfer.
// ----------------------------------------------------------------------------
interface pfn_normal_if;

  logic             valid;
  logic             ready;
  pfn_pkg::normal_t normal_x;
  pfn_pkg::normal_t normal_y;
  pfn_pkg::normal_t normal_z;
  logic             degenerate;

  modport source (
    output valid,
    output normal_x,
    output normal_y,
    output normal_z,
    output degenerate,
    input  ready
  );

  modport sink (
    input  valid,
    input  normal_x,
    input  normal_y,
    input  normal_z,
    input  degenerate,
    output ready
  );

endinterface

FILE: rtl/core/polygon_face_normal_unit.sv
// ----------------------------------------------------------------------------
// polygon_face_normal_unit: Newell polygon normal with Q1.14 normalization
// Accumulates edge cross terms over a vertex stream and emits the unit normal.
// ----------------------------------------------------------------------------
// Usage. Vertices of a polygon arrive on vertex_i, one per transfer, in order;
// the transfer with last_vertex set closes the polygon. Only the first
// MAX_VERTICES vertices count; extra ones are dropped, but a dropped vertex that
// carries last_vertex still closes the polygon. For each closed polygon one
// transfer leaves on normal_o with the unit normal in signed Q1.14, or a zero
// vector with degenerate set when fewer than three vertices were taken or the
// sums are all zero.
// Sequencing. A shared multiplier produces the x, y and z edge terms in turn, so
// the input is not ready while a vertex after the first is accumulated; the
// first is taken without a stall. Closing a polygon runs the closing edge, the
// one-bit normalizing shifts, the squares, a bit-pair square root and a
// restoring division for each of the three axes; the square root and the
// division are both bit-serial.
// Reset clears the polygon state and drops any pending result. A stalled
// receiver does not block the next polygon's accumulation: the result sits in
// the output register, and only the next result waits for that slot.
// ----------------------------------------------------------------------------
module polygon_face_normal_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  pfn_vertex_if.sink   vertex_i,
  pfn_normal_if.source normal_o
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_EDGE   = 4'd1;
  localparam logic [ST_W-1:0] ST_CHECK  = 4'd2;
  localparam logic [ST_W-1:0] ST_NORM   = 4'd3;
  localparam logic [ST_W-1:0] ST_SQUARE = 4'd4;
  localparam logic [ST_W-1:0] ST_ROOT   = 4'd5;
  localparam logic [ST_W-1:0] ST_DLOAD  = 4'd6;
  localparam logic [ST_W-1:0] ST_DSTEP  = 4'd7;
  localparam logic [ST_W-1:0] ST_FIN    = 4'd8;

  // Axis selection during the division pass.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Multiplier pipeline steps: issue term 0, 1, 2, then drain.
  localparam logic [1:0] STEP_T0    = 2'd0;
  localparam logic [1:0] STEP_T1    = 2'd1;
  localparam logic [1:0] STEP_T2    = 2'd2;
  localparam logic [1:0] STEP_DRAIN = 2'd3;

  localparam logic [pfn_pkg::ROOT_W-1:0] ROOT_BIT_INIT =
    {1'b1, {(pfn_pkg::ROOT_W-1){1'b0}}};

  logic [ST_W-1:0]                state_q;
  logic [pfn_pkg::COUNT_W-1:0]    count_q;
  logic                           last_q;
  logic                           closing_q;
  logic [1:0]                     step_q;
  logic [1:0]                     comp_q;
  logic [pfn_pkg::BITCNT_W-1:0]   bitcnt_q;

  pfn_pkg::vertex_t               first_q;
  pfn_pkg::vertex_t               prev_q;
  pfn_pkg::vertex_t               edge_a_q;
  pfn_pkg::vertex_t               edge_b_q;
  pfn_pkg::vertex_t               cur;

  logic signed [pfn_pkg::SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic [pfn_pkg::MAG_W-1:0]        mag_x_q, mag_y_q, mag_z_q;
  logic                             neg_x_q, neg_y_q, neg_z_q;

  logic [pfn_pkg::SQ_W-1:0]   sq_q;
  logic [pfn_pkg::SQ_W-1:0]   rad_q;
  logic [pfn_pkg::ROOT_W-1:0] res_q;
  logic [pfn_pkg::ROOT_W-1:0] bit_q;

  logic [pfn_pkg::DIV_W-1:0]  rem_q;
  logic [pfn_pkg::FRAC_W-1:0] numlo_q;
  logic [pfn_pkg::FRAC_W-1:0] quo_q;

  pfn_pkg::normal_t res_nx_q, res_ny_q, res_nz_q;
  logic             res_deg_q;
  pfn_pkg::normal_t out_nx_q, out_ny_q, out_nz_q;
  logic             out_deg_q;
  logic             out_valid_q;

  logic vtx_xfer;
  logic out_xfer;

  assign vertex_i.ready = (state_q == ST_IDLE);
  assign vtx_xfer       = vertex_i.valid && vertex_i.ready;
  assign out_xfer       = out_valid_q && normal_o.ready;

  assign normal_o.valid      = out_valid_q;
  assign normal_o.normal_x   = out_nx_q;
  assign normal_o.normal_y   = out_ny_q;
  assign normal_o.normal_z   = out_nz_q;
  assign normal_o.degenerate = out_deg_q;

  assign cur.x = vertex_i.coord_x;
  assign cur.y = vertex_i.coord_y;
  assign cur.z = vertex_i.coord_z;

  // --------------------------------------------------------------------------
  // Shared multiplier. It forms the x, y and z edge terms (coordinate sum
  // times coordinate difference) and later the squares of the normalized
  // magnitudes. The product is registered, so each term is accumulated in the
  // cycle after it was issued.
  // --------------------------------------------------------------------------
  logic signed [pfn_pkg::EDGE_W-1:0] esum, ediff;
  logic signed [pfn_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [pfn_pkg::PROD_W-1:0] mul_q;
  logic [pfn_pkg::MAG_W-1:0]         sq_mag;

  always_comb begin
    esum  = '0;
    ediff = '0;
    case (step_q)
      STEP_T0: begin
        esum  = {edge_a_q.z[pfn_pkg::COORD_W-1], edge_a_q.z} +
                {edge_b_q.z[pfn_pkg::COORD_W-1], edge_b_q.z};
        ediff = {edge_a_q.y[pfn_pkg::COORD_W-1], edge_a_q.y} -
                {edge_b_q.y[pfn_pkg::COORD_W-1], edge_b_q.y};
      end
      STEP_T1: begin
        esum  = {edge_a_q.x[pfn_pkg::COORD_W-1], edge_a_q.x} +
                {edge_b_q.x[pfn_pkg::COORD_W-1], edge_b_q.x};
        ediff = {edge_a_q.z[pfn_pkg::COORD_W-1], edge_a_q.z} -
                {edge_b_q.z[pfn_pkg::COORD_W-1], edge_b_q.z};
      end
      STEP_T2: begin
        esum  = {edge_a_q.y[pfn_pkg::COORD_W-1], edge_a_q.y} +
                {edge_b_q.y[pfn_pkg::COORD_W-1], edge_b_q.y};
        ediff = {edge_a_q.x[pfn_pkg::COORD_W-1], edge_a_q.x} -
                {edge_b_q.x[pfn_pkg::COORD_W-1], edge_b_q.x};
      end
      default: begin
        esum  = '0;
        ediff = '0;
      end
    endcase
  end

  always_comb begin
    case (step_q)
      STEP_T0: sq_mag = mag_x_q;
      STEP_T1: sq_mag = mag_y_q;
      default: sq_mag = mag_z_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_SQUARE) begin
      mul_a = {1'b0, sq_mag[pfn_pkg::SCALED_W-1:0]};
      mul_b = {1'b0, sq_mag[pfn_pkg::SCALED_W-1:0]};
    end else begin
      mul_a = {{(pfn_pkg::MUL_W-pfn_pkg::EDGE_W){esum[pfn_pkg::EDGE_W-1]}}, esum};
      mul_b = {{(pfn_pkg::MUL_W-pfn_pkg::EDGE_W){ediff[pfn_pkg::EDGE_W-1]}}, ediff};
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  logic signed [pfn_pkg::SUM_W-1:0] edge_term;
  logic [pfn_pkg::SQ_W-1:0]         sq_next;

  assign edge_term = $signed(mul_q[pfn_pkg::SUM_W-1:0]);
  assign sq_next   = sq_q + mul_q[pfn_pkg::SQ_W-1:0];

  // --------------------------------------------------------------------------
  // Shared subtractor. It does the trial compare of the square root and the
  // trial subtract of the restoring division; the borrow decides each bit.
  // --------------------------------------------------------------------------
  logic [pfn_pkg::SUB_W-1:0] sub_a, sub_b;
  logic [pfn_pkg::SUB_W:0]   sub_diff;
  logic                      sub_ge;
  logic [pfn_pkg::SUB_W-1:0] root_trial;
  logic [pfn_pkg::DIV_W:0]   div_trial;
  logic [pfn_pkg::DIV_W-1:0] divisor;

  assign root_trial = {1'b0, res_q} + {1'b0, bit_q};
  assign div_trial  = {rem_q, numlo_q[pfn_pkg::FRAC_W-1]};
  assign divisor    = {res_q[pfn_pkg::LEN_W-1:0], 1'b0};

  always_comb begin
    if (state_q == ST_ROOT) begin
      sub_a = pfn_pkg::SUB_W'(rad_q);
      sub_b = root_trial;
    end else begin
      sub_a = pfn_pkg::SUB_W'(div_trial);
      sub_b = pfn_pkg::SUB_W'(divisor);
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[pfn_pkg::SUB_W];

  // Division operands for the axis in work.
  logic [pfn_pkg::MAG_W-1:0]   div_mag;
  logic                        div_neg;
  logic [pfn_pkg::NUM_W-1:0]   numer;
  logic [pfn_pkg::FRAC_W-1:0]  quo_next;
  pfn_pkg::normal_t            quo_ext;
  pfn_pkg::normal_t            quo_signed;

  always_comb begin
    case (comp_q)
      AXIS_X: begin
        div_mag = mag_x_q;
        div_neg = neg_x_q;
      end
      AXIS_Y: begin
        div_mag = mag_y_q;
        div_neg = neg_y_q;
      end
      default: begin
        div_mag = mag_z_q;
        div_neg = neg_z_q;
      end
    endcase
  end

  // Numerator a * 2^15 + L, so that the quotient by 2L rounds half up.
  assign numer = {1'b0, div_mag[pfn_pkg::SCALED_W-1:0], {pfn_pkg::FRAC_W{1'b0}}} +
                 pfn_pkg::NUM_W'(res_q[pfn_pkg::LEN_W-1:0]);
  assign quo_next   = {quo_q[pfn_pkg::FRAC_W-2:0], sub_ge};
  assign quo_ext    = pfn_pkg::NORMAL_W'(quo_next);
  assign quo_signed = div_neg ? -quo_ext : quo_ext;

  // Normalization decisions: any magnitude at or above 2^30 shifts right,
  // all of them below 2^29 shifts left.
  logic norm_high;
  logic norm_low;
  logic sums_zero;

  assign norm_high = (mag_x_q[pfn_pkg::MAG_W-1:pfn_pkg::SCALED_W] != '0) ||
                     (mag_y_q[pfn_pkg::MAG_W-1:pfn_pkg::SCALED_W] != '0) ||
                     (mag_z_q[pfn_pkg::MAG_W-1:pfn_pkg::SCALED_W] != '0);
  assign norm_low  = !(mag_x_q[pfn_pkg::SCALED_W-1] || mag_y_q[pfn_pkg::SCALED_W-1] ||
                       mag_z_q[pfn_pkg::SCALED_W-1]);
  assign sums_zero = (sum_x_q == '0) && (sum_y_q == '0) && (sum_z_q == '0);

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      step_q      <= STEP_T0;
      comp_q      <= AXIS_X;
      bitcnt_q    <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      edge_a_q    <= '0;
      edge_b_q    <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      mag_x_q     <= '0;
      mag_y_q     <= '0;
      mag_z_q     <= '0;
      neg_x_q     <= 1'b0;
      neg_y_q     <= 1'b0;
      neg_z_q     <= 1'b0;
      sq_q        <= '0;
      rad_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      rem_q       <= '0;
      numlo_q     <= '0;
      quo_q       <= '0;
      res_nx_q    <= '0;
      res_ny_q    <= '0;
      res_nz_q    <= '0;
      res_deg_q   <= 1'b0;
      out_nx_q    <= '0;
      out_ny_q    <= '0;
      out_nz_q    <= '0;
      out_deg_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_FIN a transfer out coincides with loading the next result,
      // which keeps the output valid.
      if (out_xfer && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (vtx_xfer) begin
            last_q <= vertex_i.last_vertex;
            step_q <= STEP_T0;
            if (count_q < pfn_pkg::COUNT_W'(pfn_pkg::MAX_VERTICES)) begin
              count_q <= count_q + 1'b1;
              prev_q  <= cur;
              if (count_q == '0) begin
                // The first vertex only opens the polygon; a lone flagged
                // vertex still runs the (empty) closing edge.
                first_q <= cur;
                if (vertex_i.last_vertex) begin
                  edge_a_q  <= cur;
                  edge_b_q  <= cur;
                  closing_q <= 1'b1;
                  state_q   <= ST_EDGE;
                end
              end else begin
                edge_a_q  <= prev_q;
                edge_b_q  <= cur;
                closing_q <= 1'b0;
                state_q   <= ST_EDGE;
              end
            end else if (vertex_i.last_vertex) begin
              // Polygon is full: the flagged vertex is dropped but closes it.
              edge_a_q  <= prev_q;
              edge_b_q  <= first_q;
              closing_q <= 1'b1;
              state_q   <= ST_EDGE;
            end
          end
        end

        ST_EDGE: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            STEP_T1: sum_x_q <= sum_x_q + edge_term;
            STEP_T2: sum_y_q <= sum_y_q + edge_term;
            STEP_DRAIN: sum_z_q <= sum_z_q + edge_term;
            default: ;
          endcase
          if (step_q == STEP_DRAIN) begin
            if (closing_q) begin
              state_q <= ST_CHECK;
            end else if (last_q) begin
              edge_a_q  <= prev_q;
              edge_b_q  <= first_q;
              closing_q <= 1'b1;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end

        ST_CHECK: begin
          if ((count_q < pfn_pkg::COUNT_W'(pfn_pkg::MIN_VERTICES)) || sums_zero) begin
            res_nx_q  <= '0;
            res_ny_q  <= '0;
            res_nz_q  <= '0;
            res_deg_q <= 1'b1;
            state_q   <= ST_FIN;
          end else begin
            mag_x_q   <= sum_x_q[pfn_pkg::SUM_W-1] ? ~sum_x_q + 1'b1 : sum_x_q;
            mag_y_q   <= sum_y_q[pfn_pkg::SUM_W-1] ? ~sum_y_q + 1'b1 : sum_y_q;
            mag_z_q   <= sum_z_q[pfn_pkg::SUM_W-1] ? ~sum_z_q + 1'b1 : sum_z_q;
            neg_x_q   <= sum_x_q[pfn_pkg::SUM_W-1];
            neg_y_q   <= sum_y_q[pfn_pkg::SUM_W-1];
            neg_z_q   <= sum_z_q[pfn_pkg::SUM_W-1];
            res_deg_q <= 1'b0;
            state_q   <= ST_NORM;
          end
        end

        ST_NORM: begin
          // Repeated one-bit truncating shifts equal one shift by the total.
          if (norm_high) begin
            mag_x_q <= mag_x_q >> 1;
            mag_y_q <= mag_y_q >> 1;
            mag_z_q <= mag_z_q >> 1;
          end else if (norm_low) begin
            mag_x_q <= mag_x_q << 1;
            mag_y_q <= mag_y_q << 1;
            mag_z_q <= mag_z_q << 1;
          end else begin
            sq_q    <= '0;
            step_q  <= STEP_T0;
            state_q <= ST_SQUARE;
          end
        end

        ST_SQUARE: begin
          step_q <= step_q + 1'b1;
          if (step_q != STEP_T0) begin
            sq_q <= sq_next;
          end
          if (step_q == STEP_DRAIN) begin
            rad_q   <= sq_next;
            res_q   <= '0;
            bit_q   <= ROOT_BIT_INIT;
            state_q <= ST_ROOT;
          end
        end

        ST_ROOT: begin
          if (sub_ge) begin
            rad_q <= sub_diff[pfn_pkg::SQ_W-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            comp_q  <= AXIS_X;
            state_q <= ST_DLOAD;
          end
        end

        ST_DLOAD: begin
          // The top part of the numerator is already below the divisor.
          rem_q    <= pfn_pkg::DIV_W'(numer[pfn_pkg::NUM_W-1:pfn_pkg::FRAC_W]);
          numlo_q  <= numer[pfn_pkg::FRAC_W-1:0];
          quo_q    <= '0;
          bitcnt_q <= '0;
          state_q  <= ST_DSTEP;
        end

        ST_DSTEP: begin
          if (sub_ge) begin
            rem_q <= sub_diff[pfn_pkg::DIV_W-1:0];
          end else begin
            rem_q <= div_trial[pfn_pkg::DIV_W-1:0];
          end
          numlo_q  <= numlo_q << 1;
          quo_q    <= quo_next;
          bitcnt_q <= bitcnt_q + 1'b1;
          if (bitcnt_q == pfn_pkg::BITCNT_W'(pfn_pkg::FRAC_W - 1)) begin
            case (comp_q)
              AXIS_X: res_nx_q <= quo_signed;
              AXIS_Y: res_ny_q <= quo_signed;
              default: res_nz_q <= quo_signed;
            endcase
            if (comp_q == AXIS_Z) begin
              state_q <= ST_FIN;
            end else begin
              comp_q  <= comp_q + 1'b1;
              state_q <= ST_DLOAD;
            end
          end
        end

        ST_FIN: begin
          // Hand the result to the output register once it is free, then
          // start the next polygon from a clean state.
          if (!out_valid_q || normal_o.ready) begin
            out_nx_q    <= res_nx_q;
            out_ny_q    <= res_ny_q;
            out_nz_q    <= res_nz_q;
            out_deg_q   <= res_deg_q;
            out_valid_q <= 1'b1;
            count_q     <= '0;
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            sum_z_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The vertex count never passes the polygon limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pfn_pkg::COUNT_W'(pfn_pkg::MAX_VERTICES))
    else $error("vertex count above limit");

  // A degenerate result always carries the zero vector.
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_o.valid && normal_o.degenerate) |->
      (normal_o.normal_x == '0 && normal_o.normal_y == '0 && normal_o.normal_z == '0))
    else $error("degenerate result with nonzero normal");

  // Every component of a proper normal lies within plus or minus one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_o.valid && !normal_o.degenerate) |->
      (normal_o.normal_x <= pfn_pkg::UNIT_ONE && normal_o.normal_x >= -pfn_pkg::UNIT_ONE &&
       normal_o.normal_y <= pfn_pkg::UNIT_ONE && normal_o.normal_y >= -pfn_pkg::UNIT_ONE &&
       normal_o.normal_z <= pfn_pkg::UNIT_ONE && normal_o.normal_z >= -pfn_pkg::UNIT_ONE))
    else $error("normal component out of range");

  // After normalization the length lies in [2^29, 2^31), so the divisor
  // is well formed whenever a division starts.
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DLOAD) |->
      (res_q[pfn_pkg::ROOT_W-1:pfn_pkg::LEN_W] == '0 &&
       res_q[pfn_pkg::LEN_W-1:pfn_pkg::LEN_W-2] != 2'b00))
    else $error("square root outside expected range");
`endif

endmodule
